@@ sv/ipv4_pkg.sv @@
package ipv4_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned OctetW   = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned UpperW   = 24;
  localparam int unsigned DotsW    = 2;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharTab   = 8'h09;

  localparam logic [DotsW-1:0] DotsNeeded = 2'd3;
  localparam logic [11:0]      OctetMax   = 12'd255;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

endpackage

@@ sv/ipv4_dotted_decimal_parser_unit.sv @@
// dotted-decimal ipv4 address parser
// input channel: one character word per cycle (in_char_code_i) with
// in_line_end_i marking the last character of a line; accepted when
// in_valid_i is high and in_stall_o is low.
// output channel: one word per line (out_address_o, out_status_o), taken
// when out_valid_o is high and out_stall_i is low. status 0 means a valid
// address, 1 invalid text with address zero.
// throughput: one character per cycle while in_stall_o is low, set by
// the combinational octet update (multiply by ten, add, compare with 255).
// a line's result is registered in the output or else the skid register.
// an output register plus one skid register part the two sides; the input
// stalls only while the skid register is full, so characters keep flowing
// while a finished result waits downstream.
// reset clears the parser state and both result slots; the block is ready
// as soon as reset is released.
module ipv4_dotted_decimal_parser_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ipv4_pkg::CharW-1:0]  in_char_code_i,
  input  logic                        in_line_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ipv4_pkg::AddrW-1:0]  out_address_o,
  output logic                        out_status_o
);
  import ipv4_pkg::*;

  logic [UpperW-1:0] upper_q, upper_d;
  logic [OctetW-1:0] cur_q, cur_d;
  logic [DotsW-1:0]  dots_q, dots_d;
  logic              have_q, have_d;
  logic              err_q, err_d;

  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  logic              out_status_q;
  logic              skid_valid_q;
  logic [AddrW-1:0]  skid_addr_q;
  logic              skid_status_q;

  logic              in_acc, out_take, res_new;
  logic [11:0]       oct_sum;
  logic              is_digit, is_skip;
  logic [AddrW-1:0]  res_addr;
  logic              res_status;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign res_new    = in_acc && in_line_end_i;

  assign is_digit = (in_char_code_i >= CharZero) && (in_char_code_i <= CharNine);
  assign is_skip  = (in_char_code_i == CharCr) || (in_char_code_i == CharLf) ||
                    (in_char_code_i == CharSpace) || (in_char_code_i == CharTab);
  // cur * 10 + digit
  assign oct_sum = {1'b0, cur_q, 3'b000} + {3'b000, cur_q, 1'b0}
                 + {8'h00, in_char_code_i[3:0] - CharZero[3:0]};

  // character step
  always_comb begin
    upper_d = upper_q;
    cur_d   = cur_q;
    dots_d  = dots_q;
    have_d  = have_q;
    err_d   = err_q;
    if (!err_q) begin
      if (is_digit) begin
        if (oct_sum > OctetMax) begin
          err_d = 1'b1;
        end else begin
          cur_d  = oct_sum[OctetW-1:0];
          have_d = 1'b1;
        end
      end else if (in_char_code_i == CharDot) begin
        if (!have_q || (dots_q == DotsNeeded)) begin
          err_d = 1'b1;
        end else begin
          upper_d = {upper_q[UpperW-OctetW-1:0], cur_q};
          cur_d   = '0;
          have_d  = 1'b0;
          dots_d  = dots_q + 2'd1;
        end
      end else if (!is_skip) begin
        err_d = 1'b1;
      end
    end
  end

  // end-of-line check on the updated state
  always_comb begin
    if (err_d || !have_d || (dots_d != DotsNeeded)) begin
      res_addr   = '0;
      res_status = StatusInvalid;
    end else begin
      res_addr   = {upper_d, cur_d};
      res_status = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '0;
      cur_q   <= '0;
      dots_q  <= '0;
      have_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (in_acc) begin
      if (in_line_end_i) begin
        upper_q <= '0;
        cur_q   <= '0;
        dots_q  <= '0;
        have_q  <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        upper_q <= upper_d;
        cur_q   <= cur_d;
        dots_q  <= dots_d;
        have_q  <= have_d;
        err_q   <= err_d;
      end
    end
  end

  // output register with skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_new;
      end
    end else if (res_new) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_addr_q   <= skid_addr_q;
        out_status_q <= skid_status_q;
      end else if (res_new) begin
        out_addr_q   <= res_addr;
        out_status_q <= res_status;
      end
    end else if (res_new) begin
      skid_addr_q   <= res_addr;
      skid_status_q <= res_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_address_o = out_addr_q;
  assign out_status_o  = out_status_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output slot empty");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == StatusInvalid)) |-> (out_addr_q == '0))
    else $error("invalid result carries a nonzero address");

  a_line_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_new |=> ((dots_q == '0) && !err_q && !have_q && (cur_q == '0)))
    else $error("parser state not cleared after line end");

endmodule

@@ tb/sv/tb_ipv4_dotted_decimal_parser_unit.sv @@
`timescale 1ns / 1ps

module tb_ipv4_dotted_decimal_parser_unit;
  import ipv4_pkg::*;

  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseChars  = 190;
  localparam int unsigned TailCycles  = 10;

  localparam logic [CharW-1:0] Blanks [4] = '{CharCr, CharLf, CharSpace, CharTab};

  typedef enum int unsigned {
    FlawNone,
    FlawOverflow,
    FlawShort,
    FlawLong,
    FlawDoubleDot,
    FlawLeadDot,
    FlawTrailDot,
    FlawStray
  } line_flaw_e;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             status;
  } line_result_t;

  // tracks the parse of the current line and holds the results still owed
  class address_tracker;
    logic [UpperW-1:0] upper = '0;
    logic [OctetW-1:0] octet = '0;
    logic [DotsW-1:0]  dots = '0;
    bit                have_digit = 1'b0;
    bit                bad = 1'b0;
    line_result_t      awaited[$];
    int unsigned       chars = 0;
    int unsigned       lines = 0;
    int unsigned       good_lines = 0;
    int unsigned       mismatches = 0;

    function void clear();
      upper = '0;
      octet = '0;
      dots = '0;
      have_digit = 1'b0;
      bad = 1'b0;
    endfunction

    function void take_char(logic [CharW-1:0] c, bit last);
      int unsigned  v;
      line_result_t r;
      chars++;
      // once a line is bad the rest of it is ignored
      if (!bad) begin
        if (c >= CharZero && c <= CharNine) begin
          v = int'(octet) * 10 + int'(c - CharZero);
          if (v > OctetMax) begin
            bad = 1'b1;
          end else begin
            octet = v[OctetW-1:0];
            have_digit = 1'b1;
          end
        end else if (c == CharDot) begin
          if (!have_digit || dots == DotsNeeded) begin
            bad = 1'b1;
          end else begin
            upper = {upper[UpperW-OctetW-1:0], octet};
            octet = '0;
            have_digit = 1'b0;
            dots++;
          end
        end else if (!(c inside {CharCr, CharLf, CharSpace, CharTab})) begin
          bad = 1'b1;
        end
      end
      if (last) begin
        if (bad || !have_digit || dots != DotsNeeded) begin
          r = '{address: '0, status: StatusInvalid};
        end else begin
          r = '{address: {upper, octet}, status: StatusOk};
          good_lines++;
        end
        awaited.insert(awaited.size(), r);
        lines++;
        clear();
      end
    endfunction

    function void compare_result(logic [AddrW-1:0] a, logic s);
      line_result_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result word: address %h status %0d", a, s);
      end else begin
        e = awaited.pop_front();
        if (a !== e.address || s !== e.status) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result mismatch: expected address %h status %0d, got address %h status %0d",
                     e.address, e.status, a, s);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [CharW-1:0]  in_char_code_i;
  logic              in_line_end_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [AddrW-1:0]  out_address_o;
  logic              out_status_o;

  address_tracker    trk = new;
  logic [CharW-1:0]  line_q[$];
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       cycles = 0;

  ipv4_dotted_decimal_parser_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_char_code_i (in_char_code_i),
    .in_line_end_i  (in_line_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_address_o  (out_address_o),
    .out_status_o   (out_status_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Verification failed");
    $finish;
  end

  // result side: take words, then pick the stall for the next cycle
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        trk.compare_result(out_address_o, out_status_o);
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void put_char(logic [CharW-1:0] c);
    line_q.insert(line_q.size(), c);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++)
      put_char(s[i]);
  endfunction

  function automatic void add_space();
    if ($urandom_range(0, 7) == 0)
      put_char(Blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic void add_octet(bit overflow);
    int unsigned v;
    if (overflow) begin
      v = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 99999) : $urandom_range(256, 999);
    end else begin
      case ($urandom_range(0, 9))
        0: v = 0;
        1: v = 255;
        2: v = $urandom_range(0, 9);
        3: v = $urandom_range(10, 99);
        default: v = $urandom_range(0, 255);
      endcase
    end
    // leading zeros do not change the value
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) put_char(CharZero);
    add_text($sformatf("%0d", v));
  endfunction

  // hold the word until it is taken; gaps only ever come before a word
  task automatic send_char(input logic [CharW-1:0] c, input bit last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_char_code_i <= c;
    in_line_end_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    trk.take_char(c, last);
  endtask

  task automatic send_line();
    int unsigned n;
    n = line_q.size();
    for (int unsigned i = 0; i < n; i++)
      send_char(line_q[i], i == n - 1);
    line_q.delete();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (trk.awaited.size() != 0);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned n_oct;
    int unsigned bad_pos;
    line_flaw_e  flaw;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = trk.chars + PhaseChars;
    while (trk.chars < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
        // noise line, with digits and dots mixed in
        repeat ($urandom_range(1, 16)) begin
          case ($urandom_range(0, 3))
            0: put_char(CharDot);
            1: put_char(CharZero + CharW'($urandom_range(0, 9)));
            default: put_char(CharW'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        flaw = (kind < 70) ? FlawNone : line_flaw_e'($urandom_range(FlawOverflow, FlawStray));
        n_oct = (flaw == FlawShort) ? 3 : (flaw == FlawLong) ? 5 : 4;
        bad_pos = $urandom_range(0, n_oct - 1);
        if (flaw == FlawLeadDot)
          put_char(CharDot);
        for (int unsigned i = 0; i < n_oct; i++) begin
          if (i > 0) begin
            put_char(CharDot);
            if (flaw == FlawDoubleDot && i == 1 + bad_pos % (n_oct - 1))
              put_char(CharDot);
          end
          add_space();
          add_octet(flaw == FlawOverflow && i == bad_pos);
          if (flaw == FlawStray && i == bad_pos)
            put_char(CharW'($urandom_range(0, 255)));
        end
        if (flaw == FlawTrailDot)
          put_char(CharDot);
        add_space();
      end
      send_line();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_char_code_i = '0;
    in_line_end_i  = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of the octet range
    add_text("255.0.0.1");
    send_line();
    // nothing but skipped characters
    put_char(CharSpace);
    put_char(CharTab);
    put_char(CharCr);
    put_char(CharLf);
    send_line();
    // bad characters, then a digit that must be ignored
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CharZero + 8'd1);
    send_line();
    // too few dots
    add_text("1.2.3");
    send_line();
    // dot with no digit before it
    add_text(".");
    send_line();
    // octet overflow
    add_text("256");
    send_line();

    run_phase(0, 0);
    run_phase(49, 0);
    wait_drained();
    run_phase(0, 49);
    run_phase(14, 14);
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("parsed %0d characters in %0d lines, %0d of them valid addresses",
             trk.chars, trk.lines, trk.good_lines);
    $display("traffic: steady, sender gaps, receiver stalls, both; %0d mismatches, %0d left over",
             trk.mismatches, trk.awaited.size());
    if (trk.mismatches == 0 && trk.awaited.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
